@@ hw/rtl/step_sequencer_note_scheduler_defines.svh @@
// assertion macros for the note scheduler
// no dependencies
`ifndef STEP_SEQUENCER_NOTE_SCHEDULER_DEFINES_SVH
`define STEP_SEQUENCER_NOTE_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define SSNS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSNS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ssns_pkg.sv @@
// shared types and constants of the note scheduler
// no dependencies
package ssns_pkg;

    localparam int P_LAYERS  = 8;
    localparam int P_STEPS   = 16;
    localparam int P_TARGETS = 4;

    localparam int MAX_EVENTS = 64;
    localparam int CMD_DEPTH  = 2;
    localparam int EV_DEPTH   = 2;
    localparam int DIV_NW     = 48;
    localparam int DIV_DW     = 32;

    localparam logic [2:0]  TGT_BROADCAST = 3'd4;
    localparam logic [31:0] NEVER         = 32'hFFFF_FFFF;
    localparam logic [12:0] OFFSET_MAX    = 13'd8191;

    localparam logic [23:0] FPS_RESET   = 24'd5512;
    localparam logic [15:0] FRAC_RESET  = 16'd0;
    localparam logic [4:0]  COUNT_RESET = 5'd16;
    localparam logic [3:0]  MASK_RESET  = 4'd0;

    typedef enum logic [1:0] {
        OP_BLOCK = 2'd0,
        OP_STOP  = 2'd1,
        OP_WRITE = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        CFG_FPS   = 2'd0,
        CFG_FRAC  = 2'd1,
        CFG_COUNT = 2'd2,
        CFG_MASK  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        K_BLOCK,
        K_STOP,
        K_WRITE
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOP,
        ST_POS,
        ST_ESGO,
        ST_ES,
        ST_STGO,
        ST_STEP,
        ST_MUL,
        ST_ARM,
        ST_EMIT,
        ST_OFFCHK,
        ST_DEC,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [23:0] fps;
        logic [15:0] frac;
        logic [4:0]  count;
        logic [3:0]  mask;
    } t_cfg;

    typedef struct packed {
        logic        active;
        logic        mute;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [3:0]  channel;
        logic [2:0]  tgt;
        logic [15:0] pattern;
    } t_layer;

    localparam t_layer LAYER_RESET = '{
        active: 1'b0, mute: 1'b0, note: 7'd0, velocity: 7'd0,
        channel: 4'd0, tgt: TGT_BROADCAST, pattern: 16'd0
    };

    typedef struct packed {
        t_kind       kind;
        logic [47:0] elapsed;
        logic [13:0] frames;
        logic [2:0]  layer_index;
        t_layer      layer;
    } t_cmd;

    typedef struct packed {
        logic        note_on;
        logic [3:0]  channel;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [12:0] frame_offset;
        logic [1:0]  target;
        logic        last;
    } t_event;

endpackage

@@ hw/rtl/step_sequencer_note_scheduler.sv @@
// top level of the step sequencer note scheduler
// depends on ssns_pkg, ssns_front, ssns_back, ssns_fifo and the defines header
//
// Drum step sequencer stepped once per audio block request. Requests enter a
// two-deep queue and results leave through a two-deep queue, so both sides
// may stall freely. A block request that reaches a new step runs three
// serial divisions (position in loop, step index, step in pattern) on one
// shared divider, then walks the layers, or the targets of a layer sent to
// all targets, emitting events, and may run a second such pass for
// note-offs. Block requests without a new step go straight to the note-off
// check, which may run that pass, stop requests run one note-off pass, and
// layer writes are done in the idle state. Configuration writes are always
// ready and are meant to be made only while no request is in flight.
`include "step_sequencer_note_scheduler_defines.svh"

module step_sequencer_note_scheduler import ssns_pkg::*; #(
    parameter int LAYERS  = P_LAYERS,
    parameter int STEPS   = P_STEPS,
    parameter int TARGETS = P_TARGETS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_opcode,
    input  logic        i_playing,
    input  logic [47:0] i_elapsed_frames,
    input  logic [13:0] i_block_frames,
    input  logic [2:0]  i_layer_index,
    input  logic        i_layer_active,
    input  logic        i_layer_mute,
    input  logic [6:0]  i_layer_note,
    input  logic [6:0]  i_layer_velocity,
    input  logic [3:0]  i_layer_channel,
    input  logic [2:0]  i_layer_target,
    input  logic [15:0] i_layer_pattern,
    output logic        empty,
    input  logic        pop,
    output logic        o_note_on,
    output logic [3:0]  o_channel,
    output logic [6:0]  o_note,
    output logic [6:0]  o_velocity,
    output logic [12:0] o_frame_offset,
    output logic [1:0]  o_target,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    t_cfg   r_cfg;
    logic   w_cmd_vld;
    t_cmd   w_cmd;
    logic   w_cmd_pop;
    logic   w_oq_push;
    logic   w_oq_full;
    t_event w_ev;
    t_event w_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fps   <= FPS_RESET;
            r_cfg.frac  <= FRAC_RESET;
            r_cfg.count <= COUNT_RESET;
            r_cfg.mask  <= MASK_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FPS:   r_cfg.fps   <= i_cfg_data;
                CFG_FRAC:  r_cfg.frac  <= i_cfg_data[15:0];
                CFG_COUNT: r_cfg.count <= i_cfg_data[4:0];
                CFG_MASK:  r_cfg.mask  <= i_cfg_data[3:0];
                default:   r_cfg       <= r_cfg;
            endcase
        end
    end

    ssns_front #(
        .LAYERS (LAYERS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_opcode         (i_opcode),
        .i_playing        (i_playing),
        .i_elapsed_frames (i_elapsed_frames),
        .i_block_frames   (i_block_frames),
        .i_layer_index    (i_layer_index),
        .i_layer_active   (i_layer_active),
        .i_layer_mute     (i_layer_mute),
        .i_layer_note     (i_layer_note),
        .i_layer_velocity (i_layer_velocity),
        .i_layer_channel  (i_layer_channel),
        .i_layer_target   (i_layer_target),
        .i_layer_pattern  (i_layer_pattern),
        .i_mask           (r_cfg.mask),
        .o_cmd_vld        (w_cmd_vld),
        .o_cmd            (w_cmd),
        .i_cmd_pop        (w_cmd_pop)
    );

    ssns_back #(
        .LAYERS  (LAYERS),
        .STEPS   (STEPS),
        .TARGETS (TARGETS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_cmd_vld (w_cmd_vld),
        .i_cmd     (w_cmd),
        .o_cmd_pop (w_cmd_pop),
        .o_ev_push (w_oq_push),
        .o_ev      (w_ev),
        .i_ev_full (w_oq_full)
    );

    ssns_fifo #(
        .t_data (t_event),
        .DEPTH  (EV_DEPTH)
    ) u_ev_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_oq_push),
        .i_data  (w_ev),
        .o_full  (w_oq_full),
        .i_pop   (pop),
        .o_data  (w_head),
        .o_empty (empty)
    );

    assign o_note_on      = w_head.note_on;
    assign o_channel      = w_head.channel;
    assign o_note         = w_head.note;
    assign o_velocity     = w_head.velocity;
    assign o_frame_offset = w_head.frame_offset;
    assign o_target       = w_head.target;
    assign o_last         = w_head.last;

    `SSNS_ASSERT_NOW(a_ev_no_overrun, i_clk, i_rst_n, w_oq_push, !w_oq_full, "event queue overrun")
    `SSNS_ASSERT_NOW(a_cmd_no_underrun, i_clk, i_rst_n, w_cmd_pop, w_cmd_vld, "request queue underrun")
    `SSNS_ASSERT_NEXT(a_ev_visible, i_clk, i_rst_n, w_oq_push, !empty, "pushed event not visible")
endmodule

@@ hw/rtl/ssns_fifo.sv @@
// small register queue used between the scheduler parts
// no dependencies
module ssns_fifo #(
    parameter type t_data = logic,
    parameter int  DEPTH  = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_data i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_data o_data,
    output logic  o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_data          r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end
endmodule

@@ hw/rtl/ssns_front.sv @@
// front end: takes requests, drops those without effect, queues the rest
// depends on ssns_pkg and ssns_fifo
module ssns_front import ssns_pkg::*; #(
    parameter int LAYERS = P_LAYERS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_opcode,
    input  logic        i_playing,
    input  logic [47:0] i_elapsed_frames,
    input  logic [13:0] i_block_frames,
    input  logic [2:0]  i_layer_index,
    input  logic        i_layer_active,
    input  logic        i_layer_mute,
    input  logic [6:0]  i_layer_note,
    input  logic [6:0]  i_layer_velocity,
    input  logic [3:0]  i_layer_channel,
    input  logic [2:0]  i_layer_target,
    input  logic [15:0] i_layer_pattern,
    input  logic [3:0]  i_mask,
    output logic        o_cmd_vld,
    output t_cmd        o_cmd,
    input  logic        i_cmd_pop
);
    t_cmd w_cmd;
    logic w_keep;
    logic w_empty;

    always_comb begin
        w_cmd.elapsed           = i_elapsed_frames;
        w_cmd.frames            = i_block_frames;
        w_cmd.layer_index       = i_layer_index;
        w_cmd.layer.active      = i_layer_active;
        w_cmd.layer.mute        = i_layer_mute;
        w_cmd.layer.note        = i_layer_note;
        w_cmd.layer.velocity    = i_layer_velocity;
        w_cmd.layer.channel     = i_layer_channel;
        w_cmd.layer.tgt         = (i_layer_target > TGT_BROADCAST) ? TGT_BROADCAST
                                                                   : i_layer_target;
        w_cmd.layer.pattern     = i_layer_pattern;
        w_cmd.kind              = K_BLOCK;
        w_keep                  = 1'b0;
        case (t_opcode'(i_opcode))
            OP_BLOCK: begin
                w_keep = i_playing && (i_mask != 4'd0);
            end
            OP_STOP: begin
                w_cmd.kind = K_STOP;
                w_keep     = 1'b1;
            end
            OP_WRITE: begin
                w_cmd.kind = K_WRITE;
                w_keep     = (32'(i_layer_index) < LAYERS);
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    ssns_fifo #(
        .t_data (t_cmd),
        .DEPTH  (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && w_keep),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (w_empty)
    );

    assign o_cmd_vld = !w_empty;
endmodule

@@ hw/rtl/ssns_div.sv @@
// restoring divider, one quotient bit per cycle
// depends on ssns_pkg
module ssns_div import ssns_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_dividend,
    input  logic [DIV_DW-1:0] i_divisor,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quo,
    output logic [DIV_DW-1:0] o_rem
);
    localparam int NCW = $clog2(DIV_NW);

    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_div;
    logic [NCW-1:0]    r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIV_DW:0]   w_sh;
    logic              w_ge;
    logic [DIV_DW:0]   w_diff;

    assign w_sh   = {r_rem, r_quo[DIV_NW-1]};
    assign w_ge   = (w_sh >= {1'b0, r_div});
    assign w_diff = w_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIV_DW-1:0] : w_sh[DIV_DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= NCW'(DIV_NW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - NCW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

@@ hw/rtl/ssns_back.sv @@
// back end: step timing, layer table, note event emission
// depends on ssns_pkg and ssns_div
module ssns_back import ssns_pkg::*; #(
    parameter int LAYERS  = P_LAYERS,
    parameter int STEPS   = P_STEPS,
    parameter int TARGETS = P_TARGETS
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_cmd_vld,
    input  t_cmd   i_cmd,
    output logic   o_cmd_pop,
    output logic   o_ev_push,
    output t_event o_ev,
    input  logic   i_ev_full
);
    localparam int LW = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int SW = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int TW = (TARGETS > 1) ? $clog2(TARGETS) : 1;
    localparam int NW = $clog2(MAX_EVENTS + 1);

    t_state              r_state, n_state;
    t_layer              r_ly [LAYERS];
    logic [LAYERS-1:0]   r_trig, n_trig;
    logic [31:0]         r_ftns, n_ftns;
    logic [31:0]         r_ftno, n_ftno;
    logic [47:0]         r_elapsed, n_elapsed;
    logic [13:0]         r_frames, n_frames;
    logic [23:0]         r_fps, n_fps;
    logic [15:0]         r_frac, n_frac;
    logic [6:0]          r_cnt, n_cnt;
    logic [31:0]         r_loop, n_loop;
    logic [31:0]         r_pos, n_pos;
    logic [31:0]         r_es, n_es;
    logic [SW-1:0]       r_step, n_step;
    logic [31:0]         r_p1, n_p1;
    logic [31:0]         r_p2, n_p2;
    logic [31:0]         r_delay, n_delay;
    logic                r_stop, n_stop;
    logic                r_on, n_on;
    logic [LW-1:0]       r_layer, n_layer;
    logic [TW-1:0]       r_t, n_t;
    logic [NW-1:0]       r_nev, n_nev;
    t_event              r_pend, n_pend;
    logic                r_pend_vld, n_pend_vld;

    logic                w_ly_we;
    logic [LW-1:0]       w_ly_idx;
    t_layer              w_ly;
    logic [23:0]         w_fps;
    logic [6:0]          w_cnt;
    logic [31:0]         w_loop;
    logic [32:0]         w_es1;
    logic [48:0]         w_prod2;
    logic [63:0]         w_pat64;
    logic [7:0]          w_mask8;
    logic                w_qual;
    logic                w_emit;
    logic [1:0]          w_emit_tgt;
    logic                w_mark;
    logic                w_adv;
    logic                w_stall;
    logic [12:0]         w_off;
    t_event              w_new;
    t_event              w_last_ev;
    logic                w_div_start;
    logic [DIV_NW-1:0]   w_div_a;
    logic [DIV_DW-1:0]   w_div_b;
    logic                w_div_done;
    logic [DIV_NW-1:0]   w_div_q;
    logic [DIV_DW-1:0]   w_div_r;

    ssns_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_done     (w_div_done),
        .o_quo      (w_div_q),
        .o_rem      (w_div_r)
    );

    // loop length from the current tempo settings
    always_comb begin
        w_fps  = (i_cfg.fps == 24'd0) ? 24'd1 : i_cfg.fps;
        if (i_cfg.count == 5'd0) begin
            w_cnt = 7'd1;
        end else if (7'(i_cfg.count) > 7'(STEPS)) begin
            w_cnt = 7'(STEPS);
        end else begin
            w_cnt = 7'(i_cfg.count);
        end
        w_loop = (32'(w_fps) * 32'(w_cnt)) + 32'((24'(i_cfg.frac) * 24'(w_cnt)) >> 16);
    end

    assign w_es1    = 33'(r_es) + 33'd1;
    assign w_prod2  = 49'(r_frac) * 49'(w_es1);
    assign w_ly_idx = LW'(i_cmd.layer_index);

    // per-layer emission decision
    always_comb begin
        w_ly       = r_ly[r_layer];
        w_pat64    = 64'(w_ly.pattern);
        w_mask8    = 8'(i_cfg.mask);
        w_qual     = w_ly.active && !w_ly.mute &&
                     (r_on ? w_pat64[6'(r_step)] : r_trig[r_layer]);
        w_emit     = 1'b0;
        w_emit_tgt = 2'(r_t);
        w_mark     = 1'b0;
        w_adv      = 1'b0;
        if (!w_qual) begin
            w_adv = 1'b1;
        end else if (w_ly.tgt != TGT_BROADCAST) begin
            w_emit     = 1'b1;
            w_emit_tgt = w_ly.tgt[1:0];
            w_mark     = 1'b1;
            w_adv      = 1'b1;
        end else begin
            w_emit = w_mask8[3'(r_t)];
            if (r_t == TW'(TARGETS - 1)) begin
                w_mark = 1'b1;
                w_adv  = 1'b1;
            end
        end
        w_off = (r_delay > 32'(OFFSET_MAX)) ? OFFSET_MAX : r_delay[12:0];
        w_new = '{
            note_on: r_on, channel: w_ly.channel, note: w_ly.note,
            velocity: w_ly.velocity, frame_offset: w_off, target: w_emit_tgt,
            last: 1'b0
        };
        w_last_ev      = r_pend;
        w_last_ev.last = 1'b1;
        w_stall        = r_pend_vld && i_ev_full;
    end

    always_comb begin
        n_state     = r_state;
        n_trig      = r_trig;
        n_ftns      = r_ftns;
        n_ftno      = r_ftno;
        n_elapsed   = r_elapsed;
        n_frames    = r_frames;
        n_fps       = r_fps;
        n_frac      = r_frac;
        n_cnt       = r_cnt;
        n_loop      = r_loop;
        n_pos       = r_pos;
        n_es        = r_es;
        n_step      = r_step;
        n_p1        = r_p1;
        n_p2        = r_p2;
        n_delay     = r_delay;
        n_stop      = r_stop;
        n_on        = r_on;
        n_layer     = r_layer;
        n_t         = r_t;
        n_nev       = r_nev;
        n_pend      = r_pend;
        n_pend_vld  = r_pend_vld;
        o_cmd_pop   = 1'b0;
        o_ev_push   = 1'b0;
        o_ev        = r_pend;
        w_ly_we     = 1'b0;
        w_div_start = 1'b0;
        w_div_a     = 48'(r_elapsed);
        w_div_b     = r_loop;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_vld) begin
                    o_cmd_pop = 1'b1;
                    n_nev     = '0;
                    n_layer   = '0;
                    n_t       = '0;
                    case (i_cmd.kind)
                        K_WRITE: begin
                            w_ly_we          = 1'b1;
                            n_trig[w_ly_idx] = 1'b0;
                        end
                        K_STOP: begin
                            n_ftns  = '0;
                            n_ftno  = NEVER;
                            n_stop  = 1'b1;
                            n_on    = 1'b0;
                            n_delay = '0;
                            n_state = ST_EMIT;
                        end
                        K_BLOCK: begin
                            n_stop    = 1'b0;
                            n_elapsed = i_cmd.elapsed;
                            n_frames  = i_cmd.frames;
                            n_fps     = w_fps;
                            n_frac    = i_cfg.frac;
                            n_cnt     = w_cnt;
                            n_loop    = w_loop;
                            n_state   = (32'(i_cmd.frames) > r_ftns) ? ST_LOOP : ST_OFFCHK;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOOP: begin
                w_div_start = 1'b1;
                n_state     = ST_POS;
            end
            ST_POS: begin
                if (w_div_done) begin
                    n_pos   = w_div_r;
                    n_state = ST_ESGO;
                end
            end
            ST_ESGO: begin
                w_div_start = 1'b1;
                w_div_a     = 48'(r_pos + 32'(r_frames));
                w_div_b     = 32'(r_fps);
                n_state     = ST_ES;
            end
            ST_ES: begin
                if (w_div_done) begin
                    n_es    = w_div_q[31:0];
                    n_state = ST_STGO;
                end
            end
            ST_STGO: begin
                w_div_start = 1'b1;
                w_div_a     = 48'(r_es);
                w_div_b     = 32'(r_cnt);
                n_state     = ST_STEP;
            end
            ST_STEP: begin
                if (w_div_done) begin
                    n_step  = w_div_r[SW-1:0];
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_p1    = 32'(r_fps) * w_es1[31:0];
                n_p2    = w_prod2[47:16];
                n_state = ST_ARM;
            end
            ST_ARM: begin
                n_delay = r_ftns;
                n_ftns  = r_p1 + r_p2 - r_pos;
                n_ftno  = 32'(r_fps >> 1);
                n_on    = 1'b1;
                n_layer = '0;
                n_t     = '0;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!w_stall) begin
                    if (w_emit && (r_nev < NW'(MAX_EVENTS))) begin
                        o_ev_push  = r_pend_vld;
                        n_pend     = w_new;
                        n_pend_vld = 1'b1;
                        n_nev      = r_nev + NW'(1);
                    end
                    if (w_mark && !r_stop) begin
                        n_trig[r_layer] = r_on;
                    end
                    if (w_adv) begin
                        n_t = '0;
                        if (r_layer == LW'(LAYERS - 1)) begin
                            if (r_on) begin
                                n_state = ST_OFFCHK;
                            end else if (r_stop) begin
                                n_state = ST_FLUSH;
                            end else begin
                                n_ftno  = NEVER;
                                n_state = ST_DEC;
                            end
                        end else begin
                            n_layer = r_layer + LW'(1);
                        end
                    end else begin
                        n_t = r_t + TW'(1);
                    end
                end
            end
            ST_OFFCHK: begin
                if (32'(r_frames) > r_ftno) begin
                    n_delay = r_ftno;
                    n_on    = 1'b0;
                    n_layer = '0;
                    n_t     = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_DEC;
                end
            end
            ST_DEC: begin
                n_ftns  = r_ftns - 32'(r_frames);
                n_ftno  = r_ftno - 32'(r_frames);
                n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (!r_pend_vld) begin
                    n_state = ST_IDLE;
                end else if (!i_ev_full) begin
                    o_ev_push  = 1'b1;
                    o_ev       = w_last_ev;
                    n_pend_vld = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAYERS; i++) begin
                r_ly[i] <= LAYER_RESET;
            end
        end else if (w_ly_we) begin
            r_ly[w_ly_idx] <= i_cmd.layer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_trig     <= '0;
            r_ftns     <= '0;
            r_ftno     <= NEVER;
            r_pend_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_trig     <= n_trig;
            r_ftns     <= n_ftns;
            r_ftno     <= n_ftno;
            r_pend_vld <= n_pend_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_elapsed <= n_elapsed;
        r_frames  <= n_frames;
        r_fps     <= n_fps;
        r_frac    <= n_frac;
        r_cnt     <= n_cnt;
        r_loop    <= n_loop;
        r_pos     <= n_pos;
        r_es      <= n_es;
        r_step    <= n_step;
        r_p1      <= n_p1;
        r_p2      <= n_p2;
        r_delay   <= n_delay;
        r_stop    <= n_stop;
        r_on      <= n_on;
        r_layer   <= n_layer;
        r_t       <= n_t;
        r_nev     <= n_nev;
        r_pend    <= n_pend;
    end
endmodule
